// ===== sv/pfx_pkg.sv =====
// ----------------------------------------------------------------------------
// pfx_pkg
// shared widths, character codes and status codes of the postfix evaluator
// ----------------------------------------------------------------------------
package pfx_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int STEP_W      = $clog2(DATA_W);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

endpackage

// ===== sv/pfx_stack_ram.sv =====
// ----------------------------------------------------------------------------
// pfx_stack_ram
// simple dual-port operand memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pfx_stack_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                             clk,
    input  logic                                             wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     wr_addr,
    input  logic [WIDTH-1:0]                                 wr_data,
    input  logic                                             rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     rd_addr,
    output logic [WIDTH-1:0]                                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/pfx_divider.sv =====
// ----------------------------------------------------------------------------
// pfx_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pfx_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pfx_pkg::DATA_W-1:0]  dividend,
    input  logic [pfx_pkg::DATA_W-1:0]  divisor,
    output logic                        done,
    output logic [pfx_pkg::DATA_W-1:0]  quotient
);
    import pfx_pkg::*;

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [STEP_W-1:0] step_reg,  step_next;
    logic [DATA_W:0]   rem_reg,   rem_next;
    logic [DATA_W-1:0] quo_reg,   quo_next;
    logic [DATA_W-1:0] dvs_reg,   dvs_next;
    logic [DATA_W:0]   rem_shift;
    logic [DATA_W:0]   diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        rem_shift = {rem_reg[DATA_W-1:0], quo_reg[DATA_W-1]};
        diff      = rem_shift - {1'b0, dvs_reg};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_W])
            begin
                rem_next = diff;
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift;
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/postfix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// evaluates postfix integer expressions one character word at a time
// ----------------------------------------------------------------------------
// Each character word either pushes a digit, applies + - * / to the two
// topmost operands, or is ignored. The top of stack is held in a register and
// the entries below it live in a synchronous memory of STACK_DEPTH words, so
// a digit or an ignored character is done as it is accepted, while + - *
// first read the second operand from the memory and then execute. A division
// runs through a one-bit-per-cycle divider, which is not started when the
// divisor is zero. When the word marked last_char was an operator, S_FIN
// delivers the result. The result word carries the popped top value and a
// status: ok, stack underflow, stack overflow or divide by zero; the first
// error of an expression is kept and later characters are skipped until its
// end. After each result the stack and error state are cleared. A character
// word not marked last_char is taken while a previous result still waits.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        char_valid,
    output logic                        char_ready,
    input  logic [7:0]                  char_byte,
    input  logic                        last_char,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic signed [31:0]          value,
    output pfx_pkg::status_t            status
);
    import pfx_pkg::*;

    // one-hot sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    status_t           err_reg,   err_next;
    logic [DATA_W-1:0] tos_reg,   tos_next;
    op_t               op_reg,    op_next;
    logic              last_reg,  last_next;
    logic              neg_reg,   neg_next;

    // output word register
    logic              rvalid_reg, rvalid_next;
    logic [DATA_W-1:0] value_reg,  value_next;
    status_t           status_reg, status_next;

    logic              slot_free;
    logic              accept;
    logic              do_finish;
    logic              is_digit;
    logic              is_op;
    op_t               char_op;
    logic [7:0]        digit8;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_m2;

    // memory and divider hookup
    logic              ram_we;
    logic              ram_re;
    logic [DATA_W-1:0] ram_rd_data;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_quo;
    logic [DATA_W-1:0] op_a;
    logic [DATA_W-1:0] op_b;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic [DATA_W-1:0] prod;

    pfx_stack_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (cnt_m1[ADDR_W-1:0]),
        .wr_data (tos_reg),
        .rd_en   (ram_re),
        .rd_addr (cnt_m2[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    pfx_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_a),
        .divisor  (mag_b),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign slot_free  = !rvalid_reg || result_ready;
    // a last word completes at once unless it is an operator, so it needs the slot
    assign char_ready = (state_reg == S_IDLE) && (!last_char || slot_free);
    assign accept     = char_valid && char_ready;

    assign is_digit = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
    assign digit8   = char_byte - CH_ZERO;
    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign cnt_m2   = cnt_reg - CNT_W'(2);

    always_comb
    begin
        is_op   = 1'b1;
        char_op = OP_ADD;
        case (char_byte)
            CH_PLUS:  char_op = OP_ADD;
            CH_MINUS: char_op = OP_SUB;
            CH_STAR:  char_op = OP_MUL;
            CH_SLASH: char_op = OP_DIV;
            default:  is_op   = 1'b0;
        endcase
    end

    // op_a is the deeper operand, op_b the top of stack
    assign op_a  = ram_rd_data;
    assign op_b  = tos_reg;
    assign mag_a = op_a[DATA_W-1] ? (~op_a + DATA_W'(1)) : op_a;
    assign mag_b = op_b[DATA_W-1] ? (~op_b + DATA_W'(1)) : op_b;
    assign prod  = op_a * op_b;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        err_next    = err_reg;
        tos_next    = tos_reg;
        op_next     = op_reg;
        last_next   = last_reg;
        neg_next    = neg_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        div_start   = 1'b0;
        do_finish   = 1'b0;
        value_next  = value_reg;
        status_next = status_reg;
        rvalid_next = rvalid_reg && !result_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    do_finish = last_char;
                    if (err_reg == ST_OK)
                    begin
                        if (is_digit)
                        begin
                            if (cnt_reg >= CNT_W'(STACK_DEPTH))
                            begin
                                err_next = ST_OVER;
                            end
                            else
                            begin
                                // spill the old top below the new digit
                                ram_we   = (cnt_reg != '0);
                                tos_next = {{(DATA_W-4){1'b0}}, digit8[3:0]};
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                        else if (is_op)
                        begin
                            if (cnt_reg < CNT_W'(2))
                            begin
                                err_next = ST_UNDER;
                            end
                            else
                            begin
                                // fetch the second operand, execute next cycle
                                ram_re     = 1'b1;
                                op_next    = char_op;
                                last_next  = last_char;
                                state_next = S_EXEC;
                                do_finish  = 1'b0;
                            end
                        end
                    end
                end
            end

            S_EXEC:
            begin
                cnt_next   = cnt_m1;
                state_next = last_reg ? S_FIN : S_IDLE;
                case (op_reg)
                    OP_ADD: tos_next = op_a + op_b;
                    OP_SUB: tos_next = op_a - op_b;
                    OP_MUL: tos_next = prod;
                    OP_DIV:
                    begin
                        if (op_b == '0)
                        begin
                            err_next = ST_DIVZ;
                            tos_next = '0;
                        end
                        else
                        begin
                            // operands stay in place until the quotient lands
                            div_start  = 1'b1;
                            neg_next   = op_a[DATA_W-1] ^ op_b[DATA_W-1];
                            cnt_next   = cnt_reg;
                            state_next = S_DIV;
                        end
                    end
                    default: tos_next = tos_reg;
                endcase
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    tos_next   = neg_reg ? (~div_quo + DATA_W'(1)) : div_quo;
                    cnt_next   = cnt_m1;
                    state_next = last_reg ? S_FIN : S_IDLE;
                end
            end

            S_FIN:
            begin
                if (slot_free)
                begin
                    do_finish  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // end of expression: pop the top, report, clear for the next one
        if (do_finish)
        begin
            rvalid_next = 1'b1;
            value_next  = '0;
            status_next = err_next;
            if (err_next == ST_OK)
            begin
                if (cnt_next == '0)
                begin
                    status_next = ST_UNDER;
                end
                else
                begin
                    value_next = tos_next;
                end
            end
            cnt_next = '0;
            err_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            err_reg    <= ST_OK;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            err_reg    <= err_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg    <= tos_next;
        op_reg     <= op_next;
        last_reg   <= last_next;
        neg_reg    <= neg_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign result_valid = rvalid_reg;
    assign value        = value_reg;
    assign status       = status_reg;

endmodule

// ===== test/tb_postfix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// tb_postfix_expression_evaluator
// self-checking bench for the postfix expression evaluator
// ----------------------------------------------------------------------------
// Character words are queued by a stimulus process and sent by a driver that
// idles at random. Every accepted word is run through an rpn predictor that
// keeps its own operand stack; result words are checked in order against the
// predicted value and status. The run steps through phases of sender and
// receiver idling, and holds off the receiver once so that the input stalls.
// ----------------------------------------------------------------------------
module tb_postfix_expression_evaluator;

    import pfx_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_word_t;

    typedef struct packed {
        logic [31:0] value;
        status_t     status;
    } eval_result_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #6 clk = ~clk;

    // dut ports, all known from time zero
    logic              char_valid   = 1'b0;
    logic              char_ready;
    logic [7:0]        char_byte    = 8'h20;
    logic              last_char    = 1'b0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    logic signed [31:0] value;
    status_t           status;

    postfix_expression_evaluator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_byte    (char_byte),
        .last_char    (last_char),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .value        (value),
        .status       (status)
    );

    // words waiting for the driver, filled by the stimulus process
    char_word_t   pending_words[$];
    int           words_queued   = 0;
    int           words_offered  = 0;
    int           words_accepted = 0;
    int           counted_items  = 0;

    // predicted results, oldest first
    eval_result_t due_results[$];
    int           results_predicted = 0;
    int           results_seen      = 0;
    int           fail_count        = 0;

    // idling controls, percent of cycles
    int           tx_idle_pct  = 0;
    int           rx_stall_pct = 0;

    // receiver hold-off bookkeeping
    int           hold_left = 0;
    bit           hold_done = 1'b0;

    // predictor state
    logic [31:0]  opnd_stack [STACK_DEPTH];
    int           opnd_count  = 0;
    status_t      first_error = ST_OK;

    // ------------------------------------------------------------------------
    // character classes
    // ------------------------------------------------------------------------
    function automatic bit is_digit(logic [7:0] ch);
        return ch >= CH_ZERO && ch <= CH_NINE;
    endfunction

    function automatic bit is_operator(logic [7:0] ch);
        return ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR || ch == CH_SLASH;
    endfunction

    // ------------------------------------------------------------------------
    // rpn predictor: one accepted word in, at most one result out
    // ------------------------------------------------------------------------
    function automatic void rpn_step(logic [7:0] ch, logic last);
        logic [31:0]  lhs;
        logic [31:0]  rhs;
        logic [31:0]  res;
        logic [31:0]  mag_l;
        logic [31:0]  mag_r;
        eval_result_t outcome;
        // once an error is pending, everything up to the end is skipped
        if (first_error == ST_OK) begin
            if (is_digit(ch)) begin
                if (opnd_count >= STACK_DEPTH)
                    first_error = ST_OVER;
                else begin
                    opnd_stack[opnd_count] = {24'd0, ch - CH_ZERO};
                    opnd_count++;
                end
            end else if (is_operator(ch)) begin
                if (opnd_count < 2)
                    first_error = ST_UNDER;
                else begin
                    rhs = opnd_stack[opnd_count - 1];
                    lhs = opnd_stack[opnd_count - 2];
                    case (ch)
                        CH_PLUS:  res = lhs + rhs;
                        CH_MINUS: res = lhs - rhs;
                        CH_STAR:  res = lhs * rhs;
                        default: begin
                            if (rhs == 32'd0) begin
                                first_error = ST_DIVZ;
                                res = 32'd0;
                            end else begin
                                // truncate toward zero on magnitudes, min / -1 wraps
                                mag_l = lhs[31] ? -lhs : lhs;
                                mag_r = rhs[31] ? -rhs : rhs;
                                res   = mag_l / mag_r;
                                if (lhs[31] ^ rhs[31])
                                    res = -res;
                            end
                        end
                    endcase
                    opnd_stack[opnd_count - 2] = res;
                    opnd_count--;
                end
            end
        end
        if (last) begin
            outcome.value = 32'd0;
            if (first_error == ST_OK) begin
                if (opnd_count == 0)
                    first_error = ST_UNDER;
                else
                    outcome.value = opnd_stack[opnd_count - 1];
            end
            outcome.status = first_error;
            due_results.push_back(outcome);
            results_predicted++;
            opnd_count  = 0;
            first_error = ST_OK;
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void send_char(logic [7:0] ch, logic last);
        char_word_t w;
        w.ch   = ch;
        w.last = last;
        pending_words.push_back(w);
        words_queued++;
        counted_items++;
    endfunction

    function automatic void send_str(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endfunction

    function automatic void send_expr(ref logic [7:0] toks[$]);
        for (int i = 0; i < toks.size(); i++)
            send_char(toks[i], i == toks.size() - 1);
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return CH_PLUS;
        else if (r < 60)
            return CH_MINUS;
        else if (r < 90)
            return CH_STAR;
        else
            return CH_SLASH;
    endfunction

    // any byte that is neither digit nor operator, spaces most often
    function automatic logic [7:0] pick_filler();
        logic [7:0] ch;
        if ($urandom_range(0, 1))
            return 8'h20;
        do
            ch = 8'($urandom_range(0, 255));
        while (is_digit(ch) || is_operator(ch));
        return ch;
    endfunction

    // random well-formed expression with n_ops operators
    function automatic void gen_wellformed(ref logic [7:0] toks[$], input int n_ops);
        int digits_left;
        int ops_left;
        int depth;
        digits_left = n_ops + 1;
        ops_left    = n_ops;
        depth       = 0;
        while (digits_left + ops_left > 0) begin
            if ($urandom_range(0, 6) == 0)
                toks.push_back(pick_filler());
            if (digits_left > 0 && (depth < 2 || $urandom_range(0, 1))) begin
                toks.push_back(rand_digit());
                digits_left--;
                depth++;
            end else begin
                toks.push_back(pick_op());
                ops_left--;
                depth--;
            end
        end
        // sometimes the end marker rides on an ignored character
        if ($urandom_range(0, 9) == 0)
            toks.push_back(pick_filler());
    endfunction

    // long run of digits, which may fill the stack, then a burst of operators
    function automatic void gen_deep(ref logic [7:0] toks[$], input int n_push,
                                     input int n_ops);
        repeat (n_push) toks.push_back(rand_digit());
        repeat (n_ops) toks.push_back(pick_op());
    endfunction

    // builds the most negative value (2**31 wraps), then a short tail:
    // divide by -1 wraps, minus one gives the most positive value
    function automatic void send_min_expr();
        string tails[5];
        tails = '{"01-/", "1-", "01-+", "7/", "0/"};
        send_str({"88*88**88*88***8*8*2*", tails[$urandom_range(0, 4)]});
    endfunction

    function automatic void fill_random(int n_items);
        logic [7:0] toks[$];
        int         target;
        int         kind;
        int         pos;
        target = counted_items + n_items;
        while (counted_items < target) begin
            toks.delete();
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                gen_wellformed(toks, $urandom_range(0, 3) != 0 ? $urandom_range(0, 6)
                                                              : $urandom_range(7, 20));
            end else if (kind < 75) begin
                // broken expression: drop a token or slip one in
                gen_wellformed(toks, $urandom_range(1, 6));
                pos = $urandom_range(0, toks.size() - 1);
                case ($urandom_range(0, 2))
                    0:       toks.delete(pos);
                    1:       toks.insert(pos, pick_op());
                    default: toks.insert(pos, rand_digit());
                endcase
            end else if (kind < 83) begin
                repeat ($urandom_range(1, 8)) toks.push_back(8'($urandom_range(0, 255)));
            end else if (kind < 88) begin
                gen_deep(toks, $urandom_range(56, 68), $urandom_range(0, 70));
            end else if (kind < 92) begin
                send_min_expr();
            end else begin
                // one-character expressions: empty, lone digit, lone operator
                case ($urandom_range(0, 2))
                    0:       toks.push_back(pick_filler());
                    1:       toks.push_back(rand_digit());
                    default: toks.push_back(pick_op());
                endcase
            end
            if (toks.size() > 0)
                send_expr(toks);
        end
    endfunction

    // ------------------------------------------------------------------------
    // driver: takes the next word once the previous one has been accepted
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        char_word_t w;
        if (rst_n && words_accepted == words_offered) begin
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                w = pending_words.pop_front();
                char_byte     <= w.ch;
                last_char     <= w.last;
                char_valid    <= 1'b1;
                words_offered <= words_offered + 1;
            end else begin
                char_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls, plus one long hold-off early in the run
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (hold_left > 0) begin
            result_ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (!hold_done && results_seen >= 12) begin
            // sender keeps offering words meanwhile, so the block backs up
            result_ready <= 1'b0;
            hold_left    <= 400;
            hold_done    <= 1'b1;
        end else begin
            result_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks result words, feeds accepted character words to the
    // predictor
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        eval_result_t due;
        if (rst_n) begin
            if (result_valid && result_ready) begin
                results_seen <= results_seen + 1;
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result word value %0d status %0d",
                             $time, value, status);
                    fail_count++;
                end else begin
                    due = due_results.pop_front();
                    if (value !== due.value) begin
                        $display("%0t: value mismatch expected %0d got %0d",
                                 $time, $signed(due.value), value);
                        fail_count++;
                    end
                    if (status !== due.status) begin
                        $display("%0t: status mismatch expected %0d got %0d",
                                 $time, due.status, status);
                        fail_count++;
                    end
                end
            end
            if (char_valid && char_ready) begin
                rpn_step(char_byte, last_char);
                words_accepted <= words_accepted + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0] toks[$];
        int         tx_pcts[4];
        int         rx_pcts[4];
        tx_pcts = '{0, 80, 0, 11};
        rx_pcts = '{0, 0, 80, 11};

        // directed: - * /, negative quotient, divide by zero, error
        // skipping, empty expression, bytes 00 and ff ignored, leftovers
        send_str("95-");
        send_str("27-3/");
        send_str("23*");
        send_str("50/");
        send_str("+50/");
        send_str(" ");
        send_char(8'h00, 1'b0);
        send_char(CH_ZERO + 8'd3, 1'b0);
        send_char(8'hFF, 1'b1);
        send_str("12");

        // full stack then operators, push onto full stack, most negative value
        gen_deep(toks, STACK_DEPTH, STACK_DEPTH - 1);
        send_expr(toks);
        toks.delete();
        gen_deep(toks, STACK_DEPTH + 1, 3);
        send_expr(toks);
        send_min_expr();

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct  = tx_pcts[ph];
            rx_stall_pct = rx_pcts[ph];
            fill_random(240);
            wait (words_accepted == words_queued);
        end

        // drain, then allow for a division still in flight
        wait (results_seen >= results_predicted);
        repeat (64) @(posedge clk);

        if (due_results.size() != 0)
            $display("%0t: %0d predicted results never arrived", $time, due_results.size());
        if (fail_count == 0 && due_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #9_600_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
